### design/obb_aabb_overlap_2d_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the oriented-box / aligned-box overlap core
// Shared property wrappers clocked on clk_i; OAO_ASSERT is disabled in the active-low reset.
// ----------------------------------------------------------------------------
`ifndef OBB_AABB_OVERLAP_2D_CORE_DEFINES_SVH
`define OBB_AABB_OVERLAP_2D_CORE_DEFINES_SVH

// Check a property outside of reset
`define OAO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define OAO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/oao2d_pkg.sv
// ----------------------------------------------------------------------------
// oao2d_pkg
// Widths, stage types and helper functions of the box overlap core.
// ----------------------------------------------------------------------------
package oao2d_pkg;

  // Doubled centre offset and aligned-box width
  localparam int unsigned DxW   = 35;
  localparam int unsigned WxW   = 33;
  // Magnitudes of axis components and of axis dot products
  localparam int unsigned MagW  = 16;
  localparam int unsigned DotW  = 33;
  // Stage product widths
  localparam int unsigned PdW   = 51;
  localparam int unsigned PwW   = 50;
  localparam int unsigned PhW   = 47;
  localparam int unsigned PrW   = 63;
  // Per-axis comparison terms
  localparam int unsigned DistW = 52;
  localparam int unsigned RboxW = 51;
  localparam int unsigned RobbW = 64;
  localparam int unsigned CmpW  = 72;
  localparam int unsigned Shift = 14;
  localparam int unsigned NumAxes = 4;

  // One candidate axis: |centre offset|, aligned-box radius, oriented-box radius
  typedef struct packed {
    logic [DistW-1:0]        cdist;
    logic signed [RboxW-1:0] rbox;
    logic [RobbW-1:0]        robb;
  } axis_t;

  function automatic logic [MagW-1:0] abs16(logic signed [MagW-1:0] v);
    return v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

  function automatic logic [DotW-2:0] abs_dot(logic signed [DotW-1:0] v);
    logic [DotW-1:0] n;
    n = v[DotW-1] ? DotW'(-v) : DotW'(v);
    return n[DotW-2:0];
  endfunction

  function automatic logic [DxW-2:0] abs_dx(logic signed [DxW-1:0] v);
    logic [DxW-1:0] n;
    n = v[DxW-1] ? DxW'(-v) : DxW'(v);
    return n[DxW-2:0];
  endfunction

  function automatic logic [DistW-1:0] abs_dist(logic signed [DistW-1:0] v);
    return v[DistW-1] ? DistW'(-v) : DistW'(v);
  endfunction

  // Separation on one axis: cdist * 2^14 > rbox * 2^14 + 2 * robb
  function automatic logic apart(axis_t a);
    logic signed [CmpW-1:0] d;
    logic signed [CmpW-1:0] r;
    logic signed [CmpW-1:0] o;
    d = $signed({6'd0, a.cdist, 14'd0});
    r = CmpW'(a.rbox) <<< Shift;
    o = $signed({7'd0, a.robb, 1'b0});
    return d > (r + o);
  endfunction

endpackage

### design/obb_aabb_overlap_2d_core.sv
// ----------------------------------------------------------------------------
// obb_aabb_overlap_2d_core
// Separating-axis overlap test of one oriented box against one aligned box.
//
//   Channel | Dir | Handshake             | Payload
//   --------+-----+-----------------------+------------------------------------
//   input   | in  | in_valid_i/in_ready_o | obb_*_i, box_*_i (one box pair)
//   output  | out | out_valid_o/out_ready_i | overlap_o
//
// One beat per cycle in and out unless the output stalls; three arithmetic
// register stages (offsets, products, sums) and the output register (compare).
// The whole pipe advances together; when the output register holds an
// unaccepted beat, every stage holds and in_ready_o drops in the same cycle.
// Reset clears the valid bits only; there is no clearing pass.
// ----------------------------------------------------------------------------
module obb_aabb_overlap_2d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] obb_center_x_i,
  input  logic signed [31:0] obb_center_y_i,
  input  logic signed [15:0] obb_axis_a_x_i,
  input  logic signed [15:0] obb_axis_a_y_i,
  input  logic signed [15:0] obb_axis_b_x_i,
  input  logic signed [15:0] obb_axis_b_y_i,
  input  logic        [30:0] obb_half_a_i,
  input  logic        [30:0] obb_half_b_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               overlap_o
);

  localparam int unsigned DxW  = oao2d_pkg::DxW;
  localparam int unsigned WxW  = oao2d_pkg::WxW;
  localparam int unsigned MagW = oao2d_pkg::MagW;
  localparam int unsigned DotW = oao2d_pkg::DotW;

  logic advance;

  // Stage 1: offsets, widths, axis magnitudes and dot products
  logic                   s1_valid_q;
  logic signed [DxW-1:0]  s1_dx2_q, s1_dy2_q, s1_dx2_d, s1_dy2_d;
  logic signed [WxW-1:0]  s1_wx_q, s1_wy_q, s1_wx_d, s1_wy_d;
  logic signed [15:0]     s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic [MagW-1:0]        s1_max_q, s1_may_q, s1_mbx_q, s1_mby_q;
  logic [DotW-2:0]        s1_mpaa_q, s1_mpab_q, s1_mpbb_q;
  logic [DotW-2:0]        s1_mpaa_d, s1_mpab_d, s1_mpbb_d;
  logic [30:0]            s1_ha_q, s1_hb_q;

  // Stage 2: products
  logic                   s2_valid_q;
  logic [DxW-2:0]         s2_adx_q, s2_ady_q;
  logic signed [WxW-1:0]  s2_wx_q, s2_wy_q;
  logic signed [oao2d_pkg::PdW-1:0] s2_dxa_q, s2_dya_q, s2_dxb_q, s2_dyb_q;
  logic signed [oao2d_pkg::PwW-1:0] s2_wxa_q, s2_wya_q, s2_wxb_q, s2_wyb_q;
  logic [oao2d_pkg::PhW-1:0]        s2_hax_q, s2_hbx_q, s2_hay_q, s2_hby_q;
  logic [oao2d_pkg::PrW-1:0]        s2_haa_q, s2_hbab_q, s2_haab_q, s2_hbb_q;

  // Stage 3: per-axis terms
  logic                   s3_valid_q;
  oao2d_pkg::axis_t       s3_axis_q [oao2d_pkg::NumAxes];
  oao2d_pkg::axis_t       s3_axis_d [oao2d_pkg::NumAxes];

  // Output register
  logic                              out_valid_q;
  logic                              overlap_q, overlap_d;
  logic [oao2d_pkg::NumAxes-1:0]     sep;

  // Move every stage when the output slot is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Stage 1 arithmetic
  always_comb begin
    s1_dx2_d  = (DxW'(obb_center_x_i) <<< 1) - (DxW'(box_min_x_i) + DxW'(box_max_x_i));
    s1_dy2_d  = (DxW'(obb_center_y_i) <<< 1) - (DxW'(box_min_y_i) + DxW'(box_max_y_i));
    s1_wx_d   = WxW'(box_max_x_i) - WxW'(box_min_x_i);
    s1_wy_d   = WxW'(box_max_y_i) - WxW'(box_min_y_i);
    s1_mpaa_d = oao2d_pkg::abs_dot(
                  DotW'(32'(obb_axis_a_x_i) * 32'(obb_axis_a_x_i)) +
                  DotW'(32'(obb_axis_a_y_i) * 32'(obb_axis_a_y_i)));
    s1_mpab_d = oao2d_pkg::abs_dot(
                  DotW'(32'(obb_axis_a_x_i) * 32'(obb_axis_b_x_i)) +
                  DotW'(32'(obb_axis_a_y_i) * 32'(obb_axis_b_y_i)));
    s1_mpbb_d = oao2d_pkg::abs_dot(
                  DotW'(32'(obb_axis_b_x_i) * 32'(obb_axis_b_x_i)) +
                  DotW'(32'(obb_axis_b_y_i) * 32'(obb_axis_b_y_i)));
  end

  // Stage 3 sums: world x, world y, box axis a, box axis b
  always_comb begin
    s3_axis_d[0].cdist = oao2d_pkg::DistW'(s2_adx_q);
    s3_axis_d[0].rbox  = oao2d_pkg::RboxW'(s2_wx_q);
    s3_axis_d[0].robb  = oao2d_pkg::RobbW'(s2_hax_q) + oao2d_pkg::RobbW'(s2_hbx_q);
    s3_axis_d[1].cdist = oao2d_pkg::DistW'(s2_ady_q);
    s3_axis_d[1].rbox  = oao2d_pkg::RboxW'(s2_wy_q);
    s3_axis_d[1].robb  = oao2d_pkg::RobbW'(s2_hay_q) + oao2d_pkg::RobbW'(s2_hby_q);
    s3_axis_d[2].cdist = oao2d_pkg::abs_dist(
                           oao2d_pkg::DistW'(s2_dxa_q) + oao2d_pkg::DistW'(s2_dya_q));
    s3_axis_d[2].rbox  = oao2d_pkg::RboxW'(s2_wxa_q) + oao2d_pkg::RboxW'(s2_wya_q);
    s3_axis_d[2].robb  = oao2d_pkg::RobbW'(s2_haa_q) + oao2d_pkg::RobbW'(s2_hbab_q);
    s3_axis_d[3].cdist = oao2d_pkg::abs_dist(
                           oao2d_pkg::DistW'(s2_dxb_q) + oao2d_pkg::DistW'(s2_dyb_q));
    s3_axis_d[3].rbox  = oao2d_pkg::RboxW'(s2_wxb_q) + oao2d_pkg::RboxW'(s2_wyb_q);
    s3_axis_d[3].robb  = oao2d_pkg::RobbW'(s2_haab_q) + oao2d_pkg::RobbW'(s2_hbb_q);
  end

  // Compare each axis; any strict separation clears overlap
  always_comb begin
    for (int i = 0; i < oao2d_pkg::NumAxes; i++) begin
      sep[i] = oao2d_pkg::apart(s3_axis_q[i]);
    end
    overlap_d = ~|sep;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Payload stages, held on stall
  always_ff @(posedge clk_i) begin
    if (advance) begin
      // stage 1
      s1_dx2_q  <= s1_dx2_d;
      s1_dy2_q  <= s1_dy2_d;
      s1_wx_q   <= s1_wx_d;
      s1_wy_q   <= s1_wy_d;
      s1_ax_q   <= obb_axis_a_x_i;
      s1_ay_q   <= obb_axis_a_y_i;
      s1_bx_q   <= obb_axis_b_x_i;
      s1_by_q   <= obb_axis_b_y_i;
      s1_max_q  <= oao2d_pkg::abs16(obb_axis_a_x_i);
      s1_may_q  <= oao2d_pkg::abs16(obb_axis_a_y_i);
      s1_mbx_q  <= oao2d_pkg::abs16(obb_axis_b_x_i);
      s1_mby_q  <= oao2d_pkg::abs16(obb_axis_b_y_i);
      s1_mpaa_q <= s1_mpaa_d;
      s1_mpab_q <= s1_mpab_d;
      s1_mpbb_q <= s1_mpbb_d;
      s1_ha_q   <= obb_half_a_i;
      s1_hb_q   <= obb_half_b_i;
      // stage 2
      s2_adx_q  <= oao2d_pkg::abs_dx(s1_dx2_q);
      s2_ady_q  <= oao2d_pkg::abs_dx(s1_dy2_q);
      s2_wx_q   <= s1_wx_q;
      s2_wy_q   <= s1_wy_q;
      s2_dxa_q  <= oao2d_pkg::PdW'(s1_dx2_q) * oao2d_pkg::PdW'(s1_ax_q);
      s2_dya_q  <= oao2d_pkg::PdW'(s1_dy2_q) * oao2d_pkg::PdW'(s1_ay_q);
      s2_dxb_q  <= oao2d_pkg::PdW'(s1_dx2_q) * oao2d_pkg::PdW'(s1_bx_q);
      s2_dyb_q  <= oao2d_pkg::PdW'(s1_dy2_q) * oao2d_pkg::PdW'(s1_by_q);
      s2_wxa_q  <= oao2d_pkg::PwW'(s1_wx_q) * $signed({34'd0, s1_max_q});
      s2_wya_q  <= oao2d_pkg::PwW'(s1_wy_q) * $signed({34'd0, s1_may_q});
      s2_wxb_q  <= oao2d_pkg::PwW'(s1_wx_q) * $signed({34'd0, s1_mbx_q});
      s2_wyb_q  <= oao2d_pkg::PwW'(s1_wy_q) * $signed({34'd0, s1_mby_q});
      s2_hax_q  <= oao2d_pkg::PhW'(s1_ha_q) * oao2d_pkg::PhW'(s1_max_q);
      s2_hbx_q  <= oao2d_pkg::PhW'(s1_hb_q) * oao2d_pkg::PhW'(s1_mbx_q);
      s2_hay_q  <= oao2d_pkg::PhW'(s1_ha_q) * oao2d_pkg::PhW'(s1_may_q);
      s2_hby_q  <= oao2d_pkg::PhW'(s1_hb_q) * oao2d_pkg::PhW'(s1_mby_q);
      s2_haa_q  <= oao2d_pkg::PrW'(s1_ha_q) * oao2d_pkg::PrW'(s1_mpaa_q);
      s2_hbab_q <= oao2d_pkg::PrW'(s1_hb_q) * oao2d_pkg::PrW'(s1_mpab_q);
      s2_haab_q <= oao2d_pkg::PrW'(s1_ha_q) * oao2d_pkg::PrW'(s1_mpab_q);
      s2_hbb_q  <= oao2d_pkg::PrW'(s1_hb_q) * oao2d_pkg::PrW'(s1_mpbb_q);
      // stage 3 and output
      s3_axis_q <= s3_axis_d;
      overlap_q <= overlap_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

endmodule

### design/oao2d_checker.sv
// ----------------------------------------------------------------------------
// oao2d_checker
// Port-level checks of the box overlap core, bound to the top level.
// ----------------------------------------------------------------------------
`include "obb_aabb_overlap_2d_core_defines.svh"

module oao2d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic overlap_o
);

  // Hold a stalled result beat
  `OAO_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_o), "stalled result changed")

  // Accept input exactly when the output slot frees up
  `OAO_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow output slot")

  // Deliver an accepted beat through the stage registers and the output register when the sink does not stall
  `OAO_ASSERT(a_latency, in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o, "result missing after pipeline latency")

  // Drop any result while reset is held
  `OAO_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind obb_aabb_overlap_2d_core oao2d_checker u_oao2d_checker (.*);

### dv/obb_aabb_overlap_2d_core_checker.sv
// ----------------------------------------------------------------------------
// obb_aabb_overlap_2d_core_checker
// Watches both channels of the box overlap core. It computes the separating
// axis verdict of every accepted box pair at full width, queues it, and
// compares each output beat against the oldest queued verdict.
// ----------------------------------------------------------------------------
module obb_aabb_overlap_2d_core_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] obb_center_x_i,
  input  logic signed [31:0] obb_center_y_i,
  input  logic signed [15:0] obb_axis_a_x_i,
  input  logic signed [15:0] obb_axis_a_y_i,
  input  logic signed [15:0] obb_axis_b_x_i,
  input  logic signed [15:0] obb_axis_b_y_i,
  input  logic        [30:0] obb_half_a_i,
  input  logic        [30:0] obb_half_b_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               overlap_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  // Wide signed accumulator; every axis term fits with room to spare
  typedef logic signed [127:0] acc_t;

  logic        overlap_due_q[$];
  logic        due;
  int unsigned errors_q;
  int unsigned beat_q;

  function automatic acc_t mag(acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  // One axis separates when the centre distance beats both radii together
  function automatic logic splits(acc_t cdist, acc_t rbox, acc_t robb);
    return cdist > (rbox + robb);
  endfunction

  // Separating axis test on world x, world y, box axis a and box axis b.
  // All terms sit at a common scale so the compare is exact.
  function automatic logic sat_overlap(
    input logic signed [31:0] cx_f,
    input logic signed [31:0] cy_f,
    input logic signed [15:0] ax_f,
    input logic signed [15:0] ay_f,
    input logic signed [15:0] bx_f,
    input logic signed [15:0] by_f,
    input logic        [30:0] ha_f,
    input logic        [30:0] hb_f,
    input logic signed [31:0] mnx_f,
    input logic signed [31:0] mny_f,
    input logic signed [31:0] mxx_f,
    input logic signed [31:0] mxy_f
  );
    acc_t cx, cy, ax, ay, bx, by, ha, hb, mnx, mny, mxx, mxy;
    acc_t dx2, dy2, wx, wy, ux, uy, cdist, rbox, robb;
    logic sep;
    int   i;
    cx  = acc_t'(cx_f);
    cy  = acc_t'(cy_f);
    ax  = acc_t'(ax_f);
    ay  = acc_t'(ay_f);
    bx  = acc_t'(bx_f);
    by  = acc_t'(by_f);
    ha  = acc_t'(ha_f);
    hb  = acc_t'(hb_f);
    mnx = acc_t'(mnx_f);
    mny = acc_t'(mny_f);
    mxx = acc_t'(mxx_f);
    mxy = acc_t'(mxy_f);
    // Aligned box kept doubled: centre offset and full size
    dx2 = 2 * cx - (mnx + mxx);
    dy2 = 2 * cy - (mny + mxy);
    wx  = mxx - mnx;
    wy  = mxy - mny;
    sep = 1'b0;
    // World axes
    if (splits(mag(dx2) <<< 28, wx <<< 28, (2 * (ha * mag(ax) + hb * mag(bx))) <<< 14))
      sep = 1'b1;
    if (splits(mag(dy2) <<< 28, wy <<< 28, (2 * (ha * mag(ay) + hb * mag(by))) <<< 14))
      sep = 1'b1;
    // Box axes, used as given without normalizing
    for (i = 0; i < 2; i++) begin
      ux    = (i == 0) ? ax : bx;
      uy    = (i == 0) ? ay : by;
      cdist = mag(dx2 * ux + dy2 * uy) <<< 14;
      rbox  = (wx * mag(ux) + wy * mag(uy)) <<< 14;
      robb  = ((ha * mag(ax * ux + ay * uy)) <<< 1) + ((hb * mag(bx * ux + by * uy)) <<< 1);
      if (splits(cdist, rbox, robb))
        sep = 1'b1;
    end
    return !sep;
  endfunction

  // Queue the verdict of each accepted pair, check each output beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        overlap_due_q.push_back(sat_overlap(
          obb_center_x_i, obb_center_y_i, obb_axis_a_x_i, obb_axis_a_y_i,
          obb_axis_b_x_i, obb_axis_b_y_i, obb_half_a_i, obb_half_b_i,
          box_min_x_i, box_min_y_i, box_max_x_i, box_max_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (overlap_due_q.size() == 0) begin
          if (errors_q < 10)
            $display("beat %0d: output with no pair pending, overlap %0b", beat_q, overlap_i);
          errors_q = errors_q + 1;
        end else begin
          due = overlap_due_q.pop_front();
          if (due !== overlap_i) begin
            if (errors_q < 10)
              $display("beat %0d: overlap expected %0b actual %0b", beat_q, due, overlap_i);
            errors_q = errors_q + 1;
          end
        end
        beat_q = beat_q + 1;
      end
      errors_o  <= errors_q;
      pending_o <= overlap_due_q.size();
    end
  end

endmodule

### dv/obb_aabb_overlap_2d_core_tb.sv
// ----------------------------------------------------------------------------
// obb_aabb_overlap_2d_core_tb
// Drives box pairs into the overlap core: extremes and hand-built touching,
// rotated, zero-axis, inverted and long-axis cases first, then a random mix of noise,
// near-touching and rotated scenes, under three back-pressure regimes. The
// checker beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module obb_aabb_overlap_2d_core_tb;

  localparam int ONE_Q16  = 65536;
  localparam int AXIS_ONE = 16384;
  localparam int AXIS_45  = 11585;
  localparam int MAX32    = 32'sh7fffffff;
  localparam int MIN32    = 32'sh80000000;
  localparam int AMAX     = 32767;
  localparam int AMIN     = -32768;
  localparam int HMAX     = 32'h7fffffff;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic        [30:0] ha;
    logic        [30:0] hb;
    logic signed [31:0] mnx;
    logic signed [31:0] mny;
    logic signed [31:0] mxx;
    logic signed [31:0] mxy;
  } box_pair_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] obb_center_x_i = '0;
  logic signed [31:0] obb_center_y_i = '0;
  logic signed [15:0] obb_axis_a_x_i = '0;
  logic signed [15:0] obb_axis_a_y_i = '0;
  logic signed [15:0] obb_axis_b_x_i = '0;
  logic signed [15:0] obb_axis_b_y_i = '0;
  logic        [30:0] obb_half_a_i   = '0;
  logic        [30:0] obb_half_b_i   = '0;
  logic signed [31:0] box_min_x_i    = '0;
  logic signed [31:0] box_min_y_i    = '0;
  logic signed [31:0] box_max_x_i    = '0;
  logic signed [31:0] box_max_y_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               overlap_o;

  int unsigned mismatch_cnt;
  int unsigned due_cnt;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  obb_aabb_overlap_2d_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .obb_center_x_i (obb_center_x_i),
    .obb_center_y_i (obb_center_y_i),
    .obb_axis_a_x_i (obb_axis_a_x_i),
    .obb_axis_a_y_i (obb_axis_a_y_i),
    .obb_axis_b_x_i (obb_axis_b_x_i),
    .obb_axis_b_y_i (obb_axis_b_y_i),
    .obb_half_a_i   (obb_half_a_i),
    .obb_half_b_i   (obb_half_b_i),
    .box_min_x_i    (box_min_x_i),
    .box_min_y_i    (box_min_y_i),
    .box_max_x_i    (box_max_x_i),
    .box_max_y_i    (box_max_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .overlap_o      (overlap_o)
  );

  obb_aabb_overlap_2d_core_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .obb_center_x_i (obb_center_x_i),
    .obb_center_y_i (obb_center_y_i),
    .obb_axis_a_x_i (obb_axis_a_x_i),
    .obb_axis_a_y_i (obb_axis_a_y_i),
    .obb_axis_b_x_i (obb_axis_b_x_i),
    .obb_axis_b_y_i (obb_axis_b_y_i),
    .obb_half_a_i   (obb_half_a_i),
    .obb_half_b_i   (obb_half_b_i),
    .box_min_x_i    (box_min_x_i),
    .box_min_y_i    (box_min_y_i),
    .box_max_x_i    (box_max_x_i),
    .box_max_y_i    (box_max_y_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .overlap_i      (overlap_o),
    .errors_o       (mismatch_cnt),
    .pending_o      (due_cnt)
  );

  // Clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the output channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Random value in [-2^bits, 2^bits]
  function automatic int spread(int unsigned bits);
    return int'($urandom_range(32'd2 << bits)) - (1 << bits);
  endfunction

  function automatic box_pair_t pair(
    input int cx,
    input int cy,
    input int ax,
    input int ay,
    input int bx,
    input int by,
    input int ha,
    input int hb,
    input int mnx,
    input int mny,
    input int mxx,
    input int mxy
  );
    box_pair_t p;
    p.cx  = cx;
    p.cy  = cy;
    p.ax  = 16'(ax);
    p.ay  = 16'(ay);
    p.bx  = 16'(bx);
    p.by  = 16'(by);
    p.ha  = 31'(ha);
    p.hb  = 31'(hb);
    p.mnx = mnx;
    p.mny = mny;
    p.mxx = mxx;
    p.mxy = mxy;
    return p;
  endfunction

  // Mix of raw noise, near-touching axis-aligned pairs and rotated scenes
  function automatic box_pair_t random_pair();
    box_pair_t   p;
    int unsigned kind, s;
    int          ext_x, ext_y, gap, w, ox, oy, hx, hy, ha, hb, ux, uy, t;
    logic        swap, on_x, high_side;
    kind = $urandom_range(99);
    s    = $urandom_range(6, 24);
    if (kind < 15) begin
      p.cx  = $urandom;
      p.cy  = $urandom;
      p.ax  = 16'($urandom);
      p.ay  = 16'($urandom);
      p.bx  = 16'($urandom);
      p.by  = 16'($urandom);
      p.ha  = 31'($urandom);
      p.hb  = 31'($urandom);
      p.mnx = $urandom;
      p.mny = $urandom;
      p.mxx = $urandom;
      p.mxy = $urandom;
    end else if (kind < 45) begin
      // Edges placed exactly touching or one LSB either side
      swap      = 1'($urandom_range(1));
      on_x      = 1'($urandom_range(1));
      high_side = 1'($urandom_range(1));
      ha        = int'($urandom_range(1 << s));
      hb        = int'($urandom_range(1 << s));
      p.ha      = 31'(ha);
      p.hb      = 31'(hb);
      p.cx      = spread(s + 2);
      p.cy      = spread(s + 2);
      ux        = $urandom_range(1) ? AXIS_ONE : -AXIS_ONE;
      uy        = $urandom_range(1) ? AXIS_ONE : -AXIS_ONE;
      if (!swap) begin
        p.ax  = 16'(ux);
        p.ay  = '0;
        p.bx  = '0;
        p.by  = 16'(uy);
        ext_x = ha;
        ext_y = hb;
      end else begin
        p.ax  = '0;
        p.ay  = 16'(uy);
        p.bx  = 16'(ux);
        p.by  = '0;
        ext_x = hb;
        ext_y = ha;
      end
      gap = int'($urandom_range(2)) - 1;
      w   = int'($urandom_range(1 << s));
      if (on_x) begin
        if (high_side) begin
          p.mnx = p.cx + ext_x + gap;
          p.mxx = p.mnx + w;
        end else begin
          p.mxx = p.cx - ext_x - gap;
          p.mnx = p.mxx - w;
        end
        p.mny = p.cy - int'($urandom_range(1 << s));
        p.mxy = p.cy + int'($urandom_range(1 << s));
      end else begin
        if (high_side) begin
          p.mny = p.cy + ext_y + gap;
          p.mxy = p.mny + w;
        end else begin
          p.mxy = p.cy - ext_y - gap;
          p.mny = p.mxy - w;
        end
        p.mnx = p.cx - int'($urandom_range(1 << s));
        p.mxx = p.cx + int'($urandom_range(1 << s));
      end
    end else begin
      // Rotated box near an aligned box of similar scale
      if ($urandom_range(3) == 0) begin
        p.ax = 16'(spread(15));
        p.ay = 16'(spread(15));
        p.bx = 16'(spread(15));
        p.by = 16'(spread(15));
      end else begin
        ux   = spread(14);
        uy   = spread(14);
        p.ax = 16'(ux);
        p.ay = 16'(uy);
        p.bx = 16'(-uy);
        p.by = 16'(ux);
      end
      p.ha  = 31'($urandom_range(1 << s));
      p.hb  = 31'($urandom_range(1 << s));
      p.cx  = spread(s + 1);
      p.cy  = spread(s + 1);
      hx    = int'($urandom_range(1 << s));
      hy    = int'($urandom_range(1 << s));
      ox    = spread(s + 2);
      oy    = spread(s + 2);
      p.mnx = p.cx + ox - hx;
      p.mxx = p.cx + ox + hx;
      p.mny = p.cy + oy - hy;
      p.mxy = p.cy + oy + hy;
      // Now and then an inverted aligned box
      if ($urandom_range(9) == 0) begin
        t     = p.mnx;
        p.mnx = p.mxx;
        p.mxx = t;
      end
      if ($urandom_range(9) == 0) begin
        t     = p.mny;
        p.mny = p.mxy;
        p.mxy = t;
      end
    end
    return p;
  endfunction

  // Present one pair after random idle cycles, hold it until accepted
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    obb_center_x_i <= p.cx;
    obb_center_y_i <= p.cy;
    obb_axis_a_x_i <= p.ax;
    obb_axis_a_y_i <= p.ay;
    obb_axis_b_x_i <= p.bx;
    obb_axis_b_y_i <= p.by;
    obb_half_a_i   <= p.ha;
    obb_half_b_i   <= p.hb;
    box_min_x_i    <= p.mnx;
    box_min_y_i    <= p.mny;
    box_max_x_i    <= p.mxx;
    box_max_y_i    <= p.mxy;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: light source gaps, heavy sink stalls
    src_idle_pct = 17;
    snk_idle_pct = 72;

    // Field extremes
    send_pair(pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair(MAX32, MAX32, AMAX, AMAX, AMAX, AMAX, HMAX, HMAX,
                   MIN32, MIN32, MAX32, MAX32));
    send_pair(pair(MIN32, MIN32, AMIN, AMIN, AMIN, AMIN, HMAX, HMAX,
                   MAX32, MAX32, MIN32, MIN32));
    send_pair(pair(MAX32, MIN32, AMIN, AMAX, AMAX, AMIN, 0, 0,
                   MIN32, MAX32, MIN32, MAX32));
    send_pair(pair(MIN32, MAX32, 0, 0, 0, 0, HMAX, HMAX,
                   MAX32, MIN32, MAX32, MIN32));
    send_pair(pair(0, 0, AMIN, AMIN, AMAX, AMIN, HMAX, HMAX,
                   MAX32 - 1, MAX32 - 1, MAX32, MAX32));
    // Touching edges do not separate; one LSB further does
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, ONE_Q16, ONE_Q16,
                   ONE_Q16, -ONE_Q16, 3 * ONE_Q16, ONE_Q16));
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, ONE_Q16, ONE_Q16,
                   ONE_Q16 + 1, -ONE_Q16, 3 * ONE_Q16, ONE_Q16));
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, ONE_Q16, ONE_Q16,
                   -ONE_Q16, -3 * ONE_Q16, ONE_Q16, -ONE_Q16));
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, ONE_Q16, ONE_Q16,
                   -ONE_Q16, -3 * ONE_Q16, ONE_Q16, -ONE_Q16 - 1));
    send_pair(pair(ONE_Q16, 0, 0, AXIS_ONE, -AXIS_ONE, 0, 2 * ONE_Q16, ONE_Q16,
                   2 * ONE_Q16, -ONE_Q16, 4 * ONE_Q16, ONE_Q16));
    send_pair(pair(0, 0, -AXIS_ONE, 0, 0, -AXIS_ONE, ONE_Q16, 2 * ONE_Q16,
                   -ONE_Q16, 2 * ONE_Q16, ONE_Q16, 5 * ONE_Q16));
    send_pair(pair(0, 0, -AXIS_ONE, 0, 0, -AXIS_ONE, ONE_Q16, 2 * ONE_Q16,
                   -ONE_Q16, 2 * ONE_Q16 + 1, ONE_Q16, 5 * ONE_Q16));
    // Rotated box: world axes overlap, a box axis separates or not
    send_pair(pair(0, 0, AXIS_45, AXIS_45, -AXIS_45, AXIS_45, ONE_Q16, ONE_Q16,
                   78643, 78643, 144179, 144179));
    send_pair(pair(0, 0, AXIS_45, AXIS_45, -AXIS_45, AXIS_45, ONE_Q16, ONE_Q16,
                   39322, 39322, 104858, 104858));
    // Zero axes: nothing separates on them
    send_pair(pair(0, 0, 0, 0, 0, 0, HMAX, HMAX,
                   -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16));
    send_pair(pair(0, 0, 0, 0, 0, 0, HMAX, HMAX,
                   4 * ONE_Q16, -ONE_Q16, 5 * ONE_Q16, ONE_Q16));
    // Inverted aligned box around the centre
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, 0, 0,
                   ONE_Q16, ONE_Q16, -ONE_Q16, -ONE_Q16));
    send_pair(pair(0, 0, AXIS_ONE, 0, 0, AXIS_ONE, 4 * ONE_Q16, 4 * ONE_Q16,
                   ONE_Q16, ONE_Q16, -ONE_Q16, -ONE_Q16));
    // Axes longer than unit length
    send_pair(pair(0, 0, AMAX, 0, 0, AMAX, ONE_Q16, ONE_Q16,
                   2 * ONE_Q16, -ONE_Q16, 3 * ONE_Q16, ONE_Q16));

    for (n = 0; n < 160; n++)
      send_pair(random_pair());

    // Phase two: heavy source gaps, light sink stalls
    src_idle_pct = 72;
    snk_idle_pct = 17;
    for (n = 0; n < 170; n++)
      send_pair(random_pair());

    // Phase three: back to back both ways
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (n = 0; n < 170; n++)
      send_pair(random_pair());

    // Drain the pipe, then watch a while for stray beats
    in_valid_i <= 1'b0;
    while (due_cnt != 0)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("obb_aabb_overlap_2d_core verification clean");
    end else begin
      $display("obb_aabb_overlap_2d_core verification failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #400000;
    $display("obb_aabb_overlap_2d_core verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/oao2d_pkg.sv
design/obb_aabb_overlap_2d_core.sv
design/oao2d_checker.sv
dv/obb_aabb_overlap_2d_core_checker.sv
dv/obb_aabb_overlap_2d_core_tb.sv
